/* rtl/core/olrb_pkg.sv */
// Shared types and constants for the overwriting log ring buffer.
// No dependencies.
package olrb_pkg;

    localparam int LOG_DEPTH_DEF = 1024;
    localparam int MAX_READ_DEF  = 64;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;

    localparam logic       MODE_APPEND = 1'b0;
    localparam logic       MODE_READ   = 1'b1;
    localparam logic [7:0] NUL_BYTE    = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_TERM
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;      // append item: store byte, move head (and tail if full)
        logic rd_start;   // read item: latch drain count
        logic fetch;      // issue a store read
        logic load_byte;  // move fetched byte to output, advance tail
        logic load_term;  // load NUL terminator to output
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic take_zero;  // read item drains nothing
        logic cnt_last;   // byte being loaded is the last of the run
        logic out_free;   // output register can take a new item this cycle
    } t_dp_status;

endpackage

/* rtl/core/olrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/olrb_ctrl.sv */
// Controller state machine for the overwriting log ring buffer.
// Depends on olrb_pkg.
module olrb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_mode,
    input  olrb_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output olrb_pkg::t_ctrl_cmd o_cmd
);
    import olrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode == MODE_APPEND) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        if (i_status.take_zero) begin
                            n_state = ST_TERM;
                        end else begin
                            o_cmd.fetch = 1'b1;
                            n_state     = ST_DATA;
                        end
                    end
                end
            end
            ST_DATA: begin
                // fetched byte sits in the RAM read register until taken
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_status.cnt_last) begin
                        n_state = ST_TERM;
                    end else begin
                        o_cmd.fetch = 1'b1;
                    end
                end
            end
            ST_TERM: begin
                if (i_status.out_free) begin
                    o_cmd.load_term = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/olrb_dp.sv */
// Datapath: head/tail pointers, drain counter, log store and output register.
// Depends on olrb_pkg and olrb_ram.
module olrb_dp #(
    parameter int LOG_DEPTH = olrb_pkg::LOG_DEPTH_DEF,
    parameter int MAX_READ  = olrb_pkg::MAX_READ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  olrb_pkg::t_ctrl_cmd         i_cmd,
    input  logic [olrb_pkg::CHAR_W-1:0] i_char_in,
    input  logic [olrb_pkg::LEN_W-1:0]  i_read_len,
    input  logic                        i_out_ready,
    output olrb_pkg::t_dp_status        o_status,
    output logic                        o_out_valid,
    output logic [olrb_pkg::CHAR_W-1:0] o_out_byte,
    output logic                        o_last
);
    import olrb_pkg::*;

    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(MAX_READ + 1);
    localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(LOG_DEPTH - 1);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_byte, n_out_byte;
    logic              r_last, n_last;

    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic [PTR_W:0]    held_wide;
    logic [PTR_W-1:0]  held;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  want;
    logic [CNT_W-1:0]  take;
    logic [PTR_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] rdata;

    assign head_inc = (r_head == PTR_MAX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == PTR_MAX) ? '0 : r_tail + 1'b1;

    // bytes held = (head - tail) mod depth
    always_comb begin
        if (r_head >= r_tail) begin
            held_wide = {1'b0, r_head} - {1'b0, r_tail};
        end else begin
            held_wide = {1'b0, r_head} + (PTR_W+1)'(LOG_DEPTH) - {1'b0, r_tail};
        end
        held = held_wide[PTR_W-1:0];
    end

    always_comb begin
        if (i_read_len == '0) begin
            len_sat = LEN_W'(1);
        end else if (i_read_len > LEN_W'(MAX_READ)) begin
            len_sat = LEN_W'(MAX_READ);
        end else begin
            len_sat = i_read_len;
        end
        want = len_sat - 1'b1;
        if (CMP_W'(want) > CMP_W'(held)) begin
            take = CNT_W'(held);
        end else begin
            take = CNT_W'(want);
        end
    end

    assign rd_addr = i_cmd.load_byte ? tail_inc : r_tail;

    olrb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LOG_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_head),
        .i_wdata (i_char_in),
        .i_re    (i_cmd.fetch),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_out_valid = (r_out_valid && !i_out_ready) ? 1'b1 : 1'b0;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        if (i_cmd.wr_en) begin
            n_head = head_inc;
            // full: drop the oldest byte
            if (head_inc == r_tail) begin
                n_tail = tail_inc;
            end
        end
        if (i_cmd.rd_start) begin
            n_cnt = take;
        end
        if (i_cmd.load_byte) begin
            n_tail      = tail_inc;
            n_cnt       = r_cnt - 1'b1;
            n_out_valid = 1'b1;
            n_out_byte  = rdata;
            n_last      = 1'b0;
        end
        if (i_cmd.load_term) begin
            n_out_valid = 1'b1;
            n_out_byte  = NUL_BYTE;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    assign o_status.take_zero = (take == '0);
    assign o_status.cnt_last  = (r_cnt == CNT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

endmodule

/* rtl/core/overwriting_log_ring_buffer.sv */
// Overwriting log ring buffer: top level.
// Append item: accepted while idle, one per cycle back to back.
// Read item: first byte via the store's registered read port and the output
// register, then one byte per cycle unless the output stalls, terminator after
// the last byte; the next item is taken only once the terminator is loaded.
// Reset clears head, tail and output valid; the log store is not cleared.
module overwriting_log_ring_buffer #(
    parameter int LOG_DEPTH = olrb_pkg::LOG_DEPTH_DEF,
    parameter int MAX_READ  = olrb_pkg::MAX_READ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [olrb_pkg::CHAR_W-1:0] i_char_in,
    input  logic [olrb_pkg::LEN_W-1:0]  i_read_len,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [olrb_pkg::CHAR_W-1:0] o_out_byte,
    output logic                        o_last
);
    import olrb_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    olrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    olrb_dp #(
        .LOG_DEPTH (LOG_DEPTH),
        .MAX_READ  (MAX_READ)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char_in   (i_char_in),
        .i_read_len  (i_read_len),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

/* tb/overwriting_log_ring_buffer_tb.sv */
// Testbench for overwriting_log_ring_buffer: appends and read requests,
// with a built-in predictor of the ring buffer and a per-byte result check.
// Depends on olrb_pkg and the overwriting_log_ring_buffer RTL.
`timescale 1ns / 1ps

module overwriting_log_ring_buffer_tb;
    import olrb_pkg::*;

    localparam int LOG_DEPTH     = LOG_DEPTH_DEF;
    localparam int MAX_READ      = MAX_READ_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              term;
    } t_drain_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_mode;
    logic [CHAR_W-1:0] i_char_in;
    logic [LEN_W-1:0]  i_read_len;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CHAR_W-1:0] o_out_byte;
    logic              o_last;

    // shadow copy of the log
    logic [CHAR_W-1:0] shadow_log [LOG_DEPTH];
    int unsigned       shadow_head;
    int unsigned       shadow_tail;

    t_drain_byte pending_bytes [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    overwriting_log_ring_buffer #(
        .LOG_DEPTH (LOG_DEPTH),
        .MAX_READ  (MAX_READ)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_in   (i_char_in),
        .i_read_len  (i_read_len),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Expected bytes for one accepted item, pushed onto pending_bytes.
    function automatic void predict_log_item(logic mode, logic [CHAR_W-1:0] ch,
                                             logic [LEN_W-1:0] len);
        int unsigned req;
        int unsigned held;
        int unsigned take;
        t_drain_byte b;
        if (mode == MODE_APPEND) begin
            shadow_log[shadow_head] = ch;
            shadow_head = (shadow_head + 1) % LOG_DEPTH;
            // full: drop the oldest byte
            if (shadow_head == shadow_tail)
                shadow_tail = (shadow_tail + 1) % LOG_DEPTH;
        end else begin
            req = len;
            if (req < 1) req = 1;
            if (req > MAX_READ) req = MAX_READ;
            held = (shadow_head + LOG_DEPTH - shadow_tail) % LOG_DEPTH;
            take = req - 1;
            if (take > held) take = held;
            for (int unsigned k = 0; k < take; k++) begin
                b.data = shadow_log[shadow_tail];
                b.term = 1'b0;
                pending_bytes.push_back(b);
                shadow_tail = (shadow_tail + 1) % LOG_DEPTH;
            end
            b.data = NUL_BYTE;
            b.term = 1'b1;
            pending_bytes.push_back(b);
        end
    endfunction

    task automatic note_mismatch(string what, t_drain_byte want, t_drain_byte got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     $realtime, what, want.data, want.term, got.data, got.term);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_drain_byte got;
        t_drain_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.data = o_out_byte;
            got.term = o_last;
            if (pending_bytes.size() == 0) begin
                want = '0;
                note_mismatch("unexpected item", want, got);
            end else begin
                want = pending_bytes.pop_front();
                if (got.data !== want.data || got.term !== want.term)
                    note_mismatch("mismatch", want, got);
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic reset_dut();
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        shadow_head = 0;
        shadow_tail = 0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic mode, logic [CHAR_W-1:0] ch, logic [LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_char_in  <= ch;
        i_read_len <= len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_log_item(mode, ch, len);
    endtask

    task automatic append_byte(logic [CHAR_W-1:0] ch);
        send_item(MODE_APPEND, ch, LEN_W'($urandom_range(127)));
    endtask

    task automatic read_log(logic [LEN_W-1:0] len);
        send_item(MODE_READ, CHAR_W'($urandom_range(255)), len);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // extremes, zero and oversize lengths, empty and short log
    task automatic test_directed();
        read_log(7'd5);         // empty log: terminator only
        read_log(7'd0);         // zero length acts as one
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'hA5);
        append_byte(8'h5A);
        read_log(7'd1);         // terminator only, log untouched
        read_log(7'd3);         // drains two
        read_log(7'd127);       // saturates, drains the rest
        read_log(7'd64);        // empty again
        for (int k = 0; k < 8; k++)
            append_byte(CHAR_W'(8'h30 + k));
        read_log(7'd65);        // just above the cap
        append_byte(8'h7F);
        append_byte(8'h80);
        read_log(7'd2);
        read_log(7'd64);
        wait_drained();
    endtask

    // fill past the depth so the oldest bytes are overwritten, then drain
    task automatic test_overflow();
        for (int k = 0; k < LOG_DEPTH + 80; k++)
            append_byte(CHAR_W'($urandom_range(255)));
        for (int k = 0; k < LOG_DEPTH / (MAX_READ - 1) + 2; k++)
            read_log(LEN_W'($urandom_range(MAX_READ, 127)));
        wait_drained();
    endtask

    // bursts of appends, each followed by a read of random length
    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
        int sent;
        int burst;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(0, 24);
            for (int k = 0; k < burst; k++)
                append_byte(CHAR_W'($urandom_range(255)));
            pick = $urandom_range(99);
            if (pick < 80)
                read_log(LEN_W'($urandom_range(1, MAX_READ)));
            else if (pick < 90)
                read_log(LEN_W'($urandom_range(MAX_READ + 1, 127)));
            else
                read_log(7'd0);
            sent += burst + 1;
        end
        wait_drained();
    endtask

    initial begin
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_APPEND;
        i_char_in      <= '0;
        i_read_len     <= '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reset_dut();
        test_directed();
        test_overflow();
        test_random_traffic(0, 0, 125);
        test_random_traffic(50, 0, 125);
        test_random_traffic(0, 50, 125);
        test_random_traffic(12, 12, 125);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/olrb_pkg.sv
rtl/core/olrb_ram.sv
rtl/core/olrb_ctrl.sv
rtl/core/olrb_dp.sv
rtl/core/overwriting_log_ring_buffer.sv
tb/overwriting_log_ring_buffer_tb.sv
